// File: hdl/multi_camera_timestamp_grouper_unit_assert.svh
// Assertion macros shared by the timestamp grouper RTL.
`ifndef MULTI_CAMERA_TIMESTAMP_GROUPER_UNIT_ASSERT_SVH
`define MULTI_CAMERA_TIMESTAMP_GROUPER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define MCTG_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define MCTG_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hdl/mctg_pkg.sv
// Shared widths, types and register indexes of the timestamp grouper.
package mctg_pkg;
    localparam int TIME_W     = 63;
    localparam int CAM_W      = 3;
    localparam int NUMCAM_W   = 4;
    localparam int DROP_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef logic [TIME_W-1:0]    t_time;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx CFG_NUM_CAMERAS = 2'd0;
    localparam t_cfg_idx CFG_TOLERANCE   = 2'd1;
endpackage

// File: hdl/multi_camera_timestamp_grouper_unit.sv
// Top level of the multi-camera timestamp grouper: sequencer, group table and tag store.

// Each accepted frame is filed into a time-sorted table of pending groups by
// one shared 63-bit absolute-difference/compare unit under a small sequencer;
// the input stalls for the whole item. An item passes through a sorted-position
// scan, the nearest-group test, the opening of a group when needed, the tag
// write, a newest-to-oldest completeness search, a tag store read then output
// load per emitted tag, and a drop of the emitted and older groups, one slot
// per cycle. A bad camera index goes straight to the status result. Results
// leave through a registered output stage; output stalls simply hold the
// sequencer. No clearing pass is needed after reset. Configuration writes are
// always accepted.
module multi_camera_timestamp_grouper_unit #(
    parameter int MAX_GROUPS  = 16,
    parameter int MAX_CAMERAS = 8,
    parameter int TAG_BITS    = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mctg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mctg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // frame input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mctg_pkg::CAM_W-1:0]        i_camera_index,
    input  logic [mctg_pkg::TIME_W-1:0]       i_frame_time,
    input  logic [TAG_BITS-1:0]               i_frame_tag,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_group_found,
    output logic [mctg_pkg::CAM_W-1:0]        o_out_camera,
    output logic [TAG_BITS-1:0]               o_out_tag,
    output logic [mctg_pkg::TIME_W-1:0]       o_group_time,
    output logic                              o_overwrote,
    output logic                              o_bad_index,
    output logic                              o_overflow_drop,
    output logic [mctg_pkg::DROP_W-1:0]       o_groups_dropped,
    output logic                              o_last
);

    localparam int SW     = $clog2(MAX_GROUPS);
    localparam int CNT_W  = $clog2(MAX_GROUPS + 1);
    localparam int DEPTH  = MAX_GROUPS * MAX_CAMERAS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MC     = MAX_CAMERAS;
    localparam int NW     = mctg_pkg::NUMCAM_W;
    localparam int CW     = mctg_pkg::CAM_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_NEAR0 = 4'd2;
    localparam logic [3:0] ST_NEAR1 = 4'd3;
    localparam logic [3:0] ST_TOLC  = 4'd4;
    localparam logic [3:0] ST_MAKE  = 4'd5;
    localparam logic [3:0] ST_INS   = 4'd6;
    localparam logic [3:0] ST_UPD   = 4'd7;
    localparam logic [3:0] ST_SRCH  = 4'd8;
    localparam logic [3:0] ST_STAT  = 4'd9;
    localparam logic [3:0] ST_RD    = 4'd10;
    localparam logic [3:0] ST_EM    = 4'd11;
    localparam logic [3:0] ST_DROP  = 4'd12;

    // configuration
    logic [NW-1:0]           r_num_cam;
    mctg_pkg::t_time         r_tol;

    // group table, logical slot order
    mctg_pkg::t_time         r_time [MAX_GROUPS];
    logic [MC-1:0]           r_mask [MAX_GROUPS];
    logic [SW-1:0]           r_phys [MAX_GROUPS];
    logic [CNT_W-1:0]        r_count;

    // tag store, addressed by physical slot and camera
    logic [TAG_BITS-1:0]     r_tags [DEPTH];
    logic [TAG_BITS-1:0]     r_rdata;

    // sequencer and item registers
    logic [3:0]              r_state;
    logic [CNT_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_pos;
    logic [SW-1:0]           r_sel;
    logic [SW-1:0]           r_found;
    logic [SW-1:0]           r_fphys;
    logic [CW-1:0]           r_emi;
    logic [CW-1:0]           r_cam;
    mctg_pkg::t_time         r_t;
    logic [TAG_BITS-1:0]     r_tag;
    mctg_pkg::t_time         r_best;
    mctg_pkg::t_time         r_gtime;
    logic                    r_bad;
    logic                    r_ovw;
    logic                    r_ovf;

    // output stage
    logic                    r_ovalid;
    logic                    r_o_found;
    logic [CW-1:0]           r_o_cam;
    logic [TAG_BITS-1:0]     r_o_tag;
    mctg_pkg::t_time         r_o_time;
    logic                    r_o_ovw;
    logic                    r_o_bad;
    logic                    r_o_ovf;
    logic [mctg_pkg::DROP_W-1:0] r_o_drop;
    logic                    r_o_last;

    logic [NW-1:0]           w_n;
    logic [MC-1:0]           w_full;
    logic [MC-1:0]           w_cbit;
    logic [SW-1:0]           w_ix;
    mctg_pkg::t_time         w_cur_time;
    logic [MC-1:0]           w_cur_mask;
    mctg_pkg::t_time         w_diff;
    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_rot;
    logic                    w_ins;
    logic                    w_upd;
    logic                    w_emit_last;

    // effective camera count and completion mask
    always_comb begin
        if (r_num_cam == '0) begin
            w_n = NW'(1);
        end else if (r_num_cam > NW'(MC)) begin
            w_n = NW'(MC);
        end else begin
            w_n = r_num_cam;
        end
    end
    assign w_full = MC'((MC'(1) << w_n) - MC'(1));
    assign w_cbit = MC'(MC'(1) << r_cam);

    // single table read port, shared absolute-difference unit
    assign w_ix       = r_idx[SW-1:0];
    assign w_cur_time = r_time[w_ix];
    assign w_cur_mask = r_mask[w_ix];
    assign w_diff     = (w_cur_time >= r_t) ? (w_cur_time - r_t) : (r_t - w_cur_time);

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_ovalid || !i_out_stall;
    assign w_rot       = ((r_state == ST_MAKE) && (r_count >= CNT_W'(MAX_GROUPS)))
                         || (r_state == ST_DROP);
    assign w_ins       = (r_state == ST_INS);
    assign w_upd       = (r_state == ST_UPD);
    assign w_emit_last = ({1'b0, r_emi} + NW'(1)) == w_n;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cam <= NW'(2);
            r_tol     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mctg_pkg::CFG_NUM_CAMERAS: r_num_cam <= i_cfg_data[NW-1:0];
                mctg_pkg::CFG_TOLERANCE:   r_tol     <= i_cfg_data[mctg_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // table contents: rotate out the oldest slot, open a slot, set a camera bit
    always_ff @(posedge i_clk) begin
        if (w_rot) begin
            for (int i = 0; i < MAX_GROUPS; i++) begin
                r_time[i] <= r_time[(i + 1) % MAX_GROUPS];
                r_mask[i] <= r_mask[(i + 1) % MAX_GROUPS];
            end
        end else if (w_ins) begin
            for (int i = 1; i < MAX_GROUPS; i++) begin
                if ((CNT_W'(i) > r_pos) && (CNT_W'(i) <= r_count)) begin
                    r_time[i] <= r_time[i-1];
                    r_mask[i] <= r_mask[i-1];
                end
            end
            r_time[r_pos[SW-1:0]] <= r_t;
            r_mask[r_pos[SW-1:0]] <= '0;
        end else if (w_upd) begin
            r_mask[w_ix] <= w_cur_mask | w_cbit;
        end
    end

    // physical slot map, kept a permutation so tags never move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_GROUPS; i++) begin
                r_phys[i] <= SW'(i);
            end
        end else if (w_rot) begin
            for (int i = 0; i < MAX_GROUPS; i++) begin
                r_phys[i] <= r_phys[(i + 1) % MAX_GROUPS];
            end
        end else if (w_ins) begin
            for (int i = 1; i < MAX_GROUPS; i++) begin
                if ((CNT_W'(i) > r_pos) && (CNT_W'(i) <= r_count)) begin
                    r_phys[i] <= r_phys[i-1];
                end
            end
            r_phys[r_pos[SW-1:0]] <= r_phys[r_count[SW-1:0]];
        end
    end

    // tag store: write on update, registered read for emission
    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_tags[AW'(int'(r_phys[w_ix]) * MC + int'(r_cam))] <= r_tag;
        end
        if (r_state == ST_RD) begin
            r_rdata <= r_tags[AW'(int'(r_fphys) * MC + int'(r_emi))];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_idx <= '0;
                        if ({1'b0, i_camera_index} >= w_n) begin
                            r_state <= ST_STAT;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if ((r_idx < r_count) && (w_cur_time < r_t)) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end else if (r_count == '0) begin
                        r_state <= ST_MAKE;
                    end else begin
                        if (r_idx != '0) begin
                            r_idx <= r_idx - CNT_W'(1);
                        end
                        r_state <= ST_NEAR0;
                    end
                end
                ST_NEAR0: begin
                    if ((r_idx + CNT_W'(1)) < r_count) begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= ST_NEAR1;
                    end else begin
                        r_state <= ST_TOLC;
                    end
                end
                ST_NEAR1: r_state <= ST_TOLC;
                ST_TOLC: begin
                    r_idx <= CNT_W'(r_sel);
                    if (r_best > r_tol) begin
                        r_state <= ST_MAKE;
                    end else begin
                        r_state <= ST_UPD;
                    end
                end
                ST_MAKE: begin
                    if (r_count >= CNT_W'(MAX_GROUPS)) begin
                        r_count <= r_count - CNT_W'(1);
                    end
                    r_state <= ST_INS;
                end
                ST_INS: begin
                    r_count <= r_count + CNT_W'(1);
                    r_idx   <= r_pos;
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_idx   <= r_count - CNT_W'(1);
                    r_state <= ST_SRCH;
                end
                ST_SRCH: begin
                    if ((w_cur_mask & w_full) == w_full) begin
                        r_state <= ST_RD;
                    end else if (r_idx == '0) begin
                        r_state <= ST_STAT;
                    end else begin
                        r_idx <= r_idx - CNT_W'(1);
                    end
                end
                ST_STAT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_RD: r_state <= ST_EM;
                ST_EM: begin
                    if (w_out_free) begin
                        if (w_emit_last) begin
                            r_idx   <= CNT_W'(r_found);
                            r_state <= ST_DROP;
                        end else begin
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_DROP: begin
                    r_count <= r_count - CNT_W'(1);
                    if (r_idx == '0) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_idx <= r_idx - CNT_W'(1);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // item working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_cam <= i_camera_index;
                    r_t   <= i_frame_time;
                    r_tag <= i_frame_tag;
                    r_ovw <= 1'b0;
                    r_ovf <= 1'b0;
                    r_bad <= ({1'b0, i_camera_index} >= w_n);
                end
            end
            ST_SCAN: r_pos <= r_idx;
            ST_NEAR0: begin
                r_best <= w_diff;
                r_sel  <= w_ix;
            end
            ST_NEAR1: begin
                if (w_diff < r_best) begin
                    r_best <= w_diff;
                    r_sel  <= w_ix;
                end
            end
            ST_MAKE: begin
                if (r_count >= CNT_W'(MAX_GROUPS)) begin
                    r_ovf <= 1'b1;
                    if (r_pos != '0) begin
                        r_pos <= r_pos - CNT_W'(1);
                    end
                end
            end
            ST_UPD: begin
                r_ovw   <= (w_cur_mask & w_cbit) != '0;
                r_gtime <= w_cur_time;
            end
            ST_SRCH: begin
                if ((w_cur_mask & w_full) == w_full) begin
                    r_found <= w_ix;
                    r_fphys <= r_phys[w_ix];
                    r_gtime <= w_cur_time;
                    r_emi   <= '0;
                end
            end
            ST_EM: begin
                if (w_out_free) begin
                    r_emi <= r_emi + CW'(1);
                end
            end
            default: ;
        endcase
    end

    // output stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (((r_state == ST_STAT) || (r_state == ST_EM)) && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // output stage payload: status result or one tag of the completed group
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_STAT) && w_out_free) begin
            r_o_found <= 1'b0;
            r_o_cam   <= '0;
            r_o_tag   <= '0;
            r_o_time  <= r_bad ? '0 : r_gtime;
            r_o_ovw   <= r_bad ? 1'b0 : r_ovw;
            r_o_bad   <= r_bad;
            r_o_ovf   <= r_bad ? 1'b0 : r_ovf;
            r_o_drop  <= '0;
            r_o_last  <= 1'b1;
        end else if ((r_state == ST_EM) && w_out_free) begin
            r_o_found <= 1'b1;
            r_o_cam   <= r_emi;
            r_o_tag   <= r_rdata;
            r_o_time  <= r_gtime;
            r_o_ovw   <= r_ovw;
            r_o_bad   <= 1'b0;
            r_o_ovf   <= r_ovf;
            r_o_drop  <= mctg_pkg::DROP_W'(r_found);
            r_o_last  <= w_emit_last;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_group_found    = r_o_found;
    assign o_out_camera     = r_o_cam;
    assign o_out_tag        = r_o_tag;
    assign o_group_time     = r_o_time;
    assign o_overwrote      = r_o_ovw;
    assign o_bad_index      = r_o_bad;
    assign o_overflow_drop  = r_o_ovf;
    assign o_groups_dropped = r_o_drop;
    assign o_last           = r_o_last;

`include "multi_camera_timestamp_grouper_unit_assert.svh"

    `MCTG_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_GROUPS), "table count overrun")
    `MCTG_ASSERT_NEXT(a_accept_busy, w_accept, r_state != ST_IDLE, "accepted frame not started")
    `MCTG_ASSERT_NOW(a_search_nonempty, r_state == ST_SRCH, r_count != '0, "search on empty table")
    `MCTG_ASSERT_NOW(a_bad_is_last, r_ovalid && r_o_bad, r_o_last && !r_o_found, "bad index result malformed")

endmodule
